@@ hw/rtl/ppu_pkg.sv @@
package ppu_pkg;

    localparam int DEF_POOL_DEPTH = 64;
    localparam int FIELD_W        = 32;
    localparam int DT_W           = 16;
    localparam int MAXC_W         = 7;
    localparam int LIVE_W         = 7;
    localparam int KIND_W         = 2;
    localparam int NUM_SLOTS      = 8;
    localparam int ENTRY_W        = NUM_SLOTS * FIELD_W;
    localparam int IN_TDATA_W     = ENTRY_W + DT_W;
    localparam int OUT_TDATA_W    = 1 + LIVE_W + 5 * FIELD_W;

    localparam logic [MAXC_W-1:0] MAXC_RESET = 7'd64;

    // slot order inside a pool entry and inside the input word
    localparam int SLOT_PX    = 0;
    localparam int SLOT_PY    = 1;
    localparam int SLOT_VX    = 2;
    localparam int SLOT_VY    = 3;
    localparam int SLOT_RAD   = 4;
    localparam int SLOT_COLOR = 5;
    localparam int SLOT_LIFE  = 6;
    localparam int SLOT_DECAY = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK  = 2'd0,
        KIND_REC  = 2'd1,
        KIND_NONE = 2'd2
    } t_kind;

    typedef struct packed {
        logic              ld_in;
        logic              mul;
        logic              wr_add;
        logic              wr_upd;
        logic              out_ld;
        logic              rec;
        t_kind             kind;
        logic              accepted;
        logic [LIVE_W-1:0] live_total;
        logic              last;
    } t_ppu_cmd;

    typedef struct packed {
        logic survive;
        logic out_free;
    } t_ppu_sts;

endpackage

@@ hw/rtl/ppu_ram.sv @@
module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/ppu_dp.sv @@
module ppu_dp #(
    parameter int POOL_DEPTH = ppu_pkg::DEF_POOL_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ppu_pkg::t_ppu_cmd              i_cmd,
    output ppu_pkg::t_ppu_sts              o_sts,
    input  logic [$clog2(POOL_DEPTH)-1:0]  i_rd_addr,
    input  logic [$clog2(POOL_DEPTH)-1:0]  i_wr_addr,
    input  logic [ppu_pkg::IN_TDATA_W-1:0] i_in_tdata,
    input  logic                           i_out_tready,
    output logic                           o_out_tvalid,
    output logic [ppu_pkg::OUT_TDATA_W-1:0] o_out_tdata,
    output logic [ppu_pkg::KIND_W-1:0]     o_out_tuser,
    output logic                           o_out_tlast
);
    import ppu_pkg::*;

    localparam int PW = FIELD_W + 1;

    function automatic logic signed [PW-1:0] step_mul(input logic [FIELD_W-1:0] v,
                                                      input logic [DT_W-1:0] dt);
        logic signed [FIELD_W+DT_W:0] p;
        p = $signed(v) * $signed({1'b0, dt});
        // arithmetic shift floors toward minus infinity
        return p[FIELD_W+DT_W:DT_W];
    endfunction

    function automatic logic [FIELD_W-1:0] sat32(input logic signed [FIELD_W+1:0] s);
        logic [FIELD_W-1:0] r;
        if (s > $signed({3'b000, {(FIELD_W-1){1'b1}}})) begin
            r = {1'b0, {(FIELD_W-1){1'b1}}};
        end else if (s < $signed({3'b111, {(FIELD_W-1){1'b0}}})) begin
            r = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
            r = s[FIELD_W-1:0];
        end
        return r;
    endfunction

    logic [ENTRY_W-1:0] r_in_word;
    logic [DT_W-1:0]    r_dt;
    logic [ENTRY_W-1:0] w_rd_data;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [ENTRY_W-1:0] w_upd_word;

    logic signed [PW-1:0] r_mx, r_my, r_ml;
    logic [FIELD_W-1:0]   w_px, w_py, w_lf;

    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic                 r_out_acc;
    logic [LIVE_W-1:0]    r_out_live;
    logic [FIELD_W-1:0]   r_out_px, r_out_py, r_out_rad, r_out_col, r_out_life;
    logic                 r_out_last;

    ppu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_add | i_cmd.wr_upd),
        .i_waddr (i_wr_addr),
        .i_wdata (w_wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_in_word <= i_in_tdata[ENTRY_W-1:0];
            r_dt      <= i_in_tdata[IN_TDATA_W-1:ENTRY_W];
        end
        if (i_cmd.mul) begin
            r_mx <= step_mul(w_rd_data[SLOT_VX*FIELD_W +: FIELD_W], r_dt);
            r_my <= step_mul(w_rd_data[SLOT_VY*FIELD_W +: FIELD_W], r_dt);
            r_ml <= step_mul(w_rd_data[SLOT_DECAY*FIELD_W +: FIELD_W], r_dt);
        end
    end

    always_comb begin
        w_px = sat32($signed({{2{w_rd_data[SLOT_PX*FIELD_W+FIELD_W-1]}},
                              w_rd_data[SLOT_PX*FIELD_W +: FIELD_W]})
                     + $signed({r_mx[PW-1], r_mx}));
        w_py = sat32($signed({{2{w_rd_data[SLOT_PY*FIELD_W+FIELD_W-1]}},
                              w_rd_data[SLOT_PY*FIELD_W +: FIELD_W]})
                     + $signed({r_my[PW-1], r_my}));
        w_lf = sat32($signed({{2{w_rd_data[SLOT_LIFE*FIELD_W+FIELD_W-1]}},
                              w_rd_data[SLOT_LIFE*FIELD_W +: FIELD_W]})
                     - $signed({r_ml[PW-1], r_ml}));

        w_upd_word = w_rd_data;
        w_upd_word[SLOT_PX*FIELD_W +: FIELD_W]   = w_px;
        w_upd_word[SLOT_PY*FIELD_W +: FIELD_W]   = w_py;
        w_upd_word[SLOT_LIFE*FIELD_W +: FIELD_W] = w_lf;

        w_wr_data = i_cmd.wr_add ? r_in_word : w_upd_word;
    end

    assign o_sts.survive  = $signed(w_lf) > $signed({FIELD_W{1'b0}});
    assign o_sts.out_free = !r_out_valid || i_out_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_kind <= i_cmd.kind;
            r_out_acc  <= i_cmd.accepted;
            r_out_live <= i_cmd.live_total;
            r_out_last <= i_cmd.last;
            if (i_cmd.rec) begin
                r_out_px   <= w_rd_data[SLOT_PX*FIELD_W +: FIELD_W];
                r_out_py   <= w_rd_data[SLOT_PY*FIELD_W +: FIELD_W];
                r_out_rad  <= w_rd_data[SLOT_RAD*FIELD_W +: FIELD_W];
                r_out_col  <= w_rd_data[SLOT_COLOR*FIELD_W +: FIELD_W];
                r_out_life <= w_rd_data[SLOT_LIFE*FIELD_W +: FIELD_W];
            end else begin
                r_out_px   <= '0;
                r_out_py   <= '0;
                r_out_rad  <= '0;
                r_out_col  <= '0;
                r_out_life <= '0;
            end
        end
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = {r_out_life, r_out_col, r_out_rad, r_out_py, r_out_px,
                           r_out_live, r_out_acc};
    assign o_out_tuser  = r_out_kind;
    assign o_out_tlast  = r_out_last;

endmodule

@@ hw/rtl/ppu_ctrl.sv @@
module ppu_ctrl #(
    parameter int POOL_DEPTH = ppu_pkg::DEF_POOL_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppu_pkg::MAXC_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_tvalid,
    output logic                          o_in_tready,
    input  logic                          i_mode,
    input  ppu_pkg::t_ppu_sts             i_sts,
    output ppu_pkg::t_ppu_cmd             o_cmd,
    output logic [$clog2(POOL_DEPTH)-1:0] o_rd_addr,
    output logic [$clog2(POOL_DEPTH)-1:0] o_wr_addr
);
    import ppu_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ADD  = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_NONE = 8'b0010_0000,
        S_ERD  = 8'b0100_0000,
        S_ELD  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [MAXC_W-1:0] r_max_count;
    logic [CW-1:0]     r_live, n_live;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     w_cap;
    logic              w_last;

    always_comb begin
        if (32'(r_max_count) > 32'(POOL_DEPTH)) begin
            w_cap = CW'(POOL_DEPTH);
        end else begin
            w_cap = CW'(r_max_count);
        end
    end

    assign w_last = (r_j + 1'b1) == r_live;

    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_i         = r_i;
        n_n         = r_n;
        n_j         = r_j;
        o_cmd       = '0;
        o_cmd.kind  = KIND_ACK;
        o_in_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.ld_in = 1'b1;
                    n_i = '0;
                    n_n = '0;
                    if (!i_mode) begin
                        n_state = S_ADD;
                    end else if (r_live == '0) begin
                        n_state = S_NONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.kind   = KIND_ACK;
                    o_cmd.last   = 1'b1;
                    if (r_live < w_cap) begin
                        o_cmd.wr_add   = 1'b1;
                        o_cmd.accepted = 1'b1;
                        n_live = r_live + 1'b1;
                    end else begin
                        // lowered capacity discards the tail of the pool
                        n_live = w_cap;
                    end
                    o_cmd.live_total = LIVE_W'(n_live);
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                if (i_sts.survive) begin
                    o_cmd.wr_upd = 1'b1;
                    n_n = r_n + 1'b1;
                end
                n_i = r_i + 1'b1;
                if (n_i == r_live) begin
                    n_live = n_n;
                    n_j    = '0;
                    n_state = (n_n == '0) ? S_NONE : S_ERD;
                end else begin
                    n_state = S_RD;
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.kind   = KIND_NONE;
                    o_cmd.last   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ERD: begin
                n_state = S_ELD;
            end
            S_ELD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld     = 1'b1;
                    o_cmd.rec        = 1'b1;
                    o_cmd.kind       = KIND_REC;
                    o_cmd.live_total = LIVE_W'(r_live);
                    o_cmd.last       = w_last;
                    n_j = r_j + 1'b1;
                    n_state = w_last ? S_IDLE : S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr = (r_state == S_ERD || r_state == S_ELD) ? r_j[AW-1:0] : r_i[AW-1:0];
    assign o_wr_addr = (r_state == S_ADD) ? r_live[AW-1:0] : r_n[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_count <= MAXC_RESET;
            r_live      <= '0;
            r_i         <= '0;
            r_n         <= '0;
            r_j         <= '0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_i     <= n_i;
            r_n     <= n_n;
            r_j     <= n_j;
            if (i_cfg_we) begin
                r_max_count <= i_cfg_wdata;
            end
        end
    end

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(POOL_DEPTH))
        else $error("live count beyond pool depth");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_n <= r_i && r_i < r_live))
        else $error("compaction write index ahead of read index");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_sts.out_free)
        else $error("result loaded over a pending word");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_ld && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("final result did not end the item");

    a_add_grows_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_add |=> (r_live == $past(r_live) + 1'b1))
        else $error("stored particle did not raise the live count");

endmodule

@@ hw/rtl/particle_pool_update_engine.sv @@
// channel   dir  tuser         tdata / other
// s_axis    in   mode          pos_x..decay_rate, delta_time
// m_axis    out  kind          accepted, live_total, pos_x, pos_y, radius, color, life; tlast
// cfg       in   -             i_cfg_we + i_cfg_wdata = max_count
//
// Add: the result word is registered from the add state once the output is free.
// Update: each live particle passes pool read, step multiply, saturate and
// compact write; then each survivor is read and emitted as a record, or one
// none word if none survive. The pool RAM has one read and one write port. Input is taken only in idle.
// Reset clears the live count and sets max_count to 64; pool contents stay.
// A stalled output holds the sequencer in place; no word is lost.
module particle_pool_update_engine #(
    parameter int POOL_DEPTH = ppu_pkg::DEF_POOL_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppu_pkg::MAXC_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, size_radius, rgba_color, life_start,
    // decay_rate, delta_time
    input  logic [ppu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accepted, live_total, out_pos_x, out_pos_y, out_radius, out_color, out_life
    output logic [ppu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic [ppu_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast
);
    import ppu_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);

    t_ppu_cmd      w_cmd;
    t_ppu_sts      w_sts;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    ppu_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr)
    );

    ppu_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_rd_addr    (w_rd_addr),
        .i_wr_addr    (w_wr_addr),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser),
        .o_out_tlast  (m_axis_tlast)
    );

endmodule
